// ----- src/ud128_pkg.sv -----
// Shared constants and types for the 128-bit unsigned divider.
package ud128_pkg;

    localparam int FIELD_W          = 64;
    localparam int FULL_W           = 2 * FIELD_W;
    localparam int OPERAND_BITS_DEF = 128;

    // Control that travels with each pipeline slot.
    typedef struct packed {
        logic valid;
        logic dz;
    } t_ctl;

endpackage

// ----- src/ud128_if.sv -----
// Input and output channel interfaces of the divider.
interface ud128_in_if;
    logic                          valid;
    logic                          ready;
    logic [ud128_pkg::FIELD_W-1:0] dividend_hi;
    logic [ud128_pkg::FIELD_W-1:0] dividend_lo;
    logic [ud128_pkg::FIELD_W-1:0] divisor_hi;
    logic [ud128_pkg::FIELD_W-1:0] divisor_lo;

    modport source (output valid, dividend_hi, dividend_lo, divisor_hi, divisor_lo,
                    input ready);
    modport sink   (input valid, dividend_hi, dividend_lo, divisor_hi, divisor_lo,
                    output ready);
endinterface

interface ud128_out_if;
    logic                          valid;
    logic                          ready;
    logic [ud128_pkg::FIELD_W-1:0] quotient_hi;
    logic [ud128_pkg::FIELD_W-1:0] quotient_lo;
    logic [ud128_pkg::FIELD_W-1:0] remainder_hi;
    logic [ud128_pkg::FIELD_W-1:0] remainder_lo;
    logic                          divide_by_zero;

    modport source (output valid, quotient_hi, quotient_lo, remainder_hi, remainder_lo,
                    divide_by_zero, input ready);
    modport sink   (input valid, quotient_hi, quotient_lo, remainder_hi, remainder_lo,
                    divide_by_zero, output ready);
endinterface

// ----- src/ud128_stage.sv -----
// One registered restoring-division step: shift in a dividend bit, trial subtract.
module ud128_stage #(
    parameter int W = ud128_pkg::OPERAND_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ud128_pkg::t_ctl i_ctl,
    input  logic [W-1:0]    i_rem,
    input  logic [W-1:0]    i_nq,
    input  logic [W-1:0]    i_div,
    output ud128_pkg::t_ctl o_ctl,
    output logic [W-1:0]    o_rem,
    output logic [W-1:0]    o_nq,
    output logic [W-1:0]    o_div
);

    ud128_pkg::t_ctl r_ctl;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_nq;
    logic [W-1:0]    r_div;

    logic [W:0]      trial;
    logic [W+1:0]    diff;
    logic            fits;
    logic [W-1:0]    n_rem;
    logic [W-1:0]    n_nq;

    // nq holds the unconsumed dividend bits on top and quotient bits below
    always_comb begin
        trial = {i_rem, i_nq[W-1]};
        diff  = {1'b0, trial} - {2'b00, i_div};
        fits  = ~diff[W+1];
        n_rem = fits ? diff[W-1:0] : trial[W-1:0];
        n_nq  = {i_nq[W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_div <= i_div;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;
    assign o_div = r_div;

endmodule

// ----- src/unsigned_divide_128.sv -----
// Top level of the pipelined unsigned divider.
//
// Usage: operands arrive on i_in (valid/ready) as 64-bit halves of a dividend
// and a divisor; only the low OPERAND_BITS bits of each are used. Results leave
// on o_out as quotient and remainder halves plus a divide_by_zero flag.
//
// Each item passes OPERAND_BITS register stages, one quotient bit per stage
// (one trial subtract of OPERAND_BITS+1 bits each), on its way to o_out. One
// transaction per cycle can enter and leave while the output is not stalled.
//
// The last stage is the output register. When the receiver holds ready low
// while a result waits, the whole pipeline freezes and i_in.ready drops; no
// transaction is lost or repeated. Empty slots travel as bubbles.
//
// Reset clears all slot valid bits; no clearing pass is needed.
// A zero divisor gives zero quotient and remainder with divide_by_zero set.
module unsigned_divide_128 #(
    parameter int OPERAND_BITS = ud128_pkg::OPERAND_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ud128_in_if.sink    i_in,
    ud128_out_if.source o_out
);

    localparam int W = OPERAND_BITS;

    logic [ud128_pkg::FULL_W-1:0] dividend_full;
    logic [ud128_pkg::FULL_W-1:0] divisor_full;
    logic [ud128_pkg::FULL_W-1:0] quot_full;
    logic [ud128_pkg::FULL_W-1:0] rem_full;
    logic                         en;

    ud128_pkg::t_ctl s_ctl [0:W];
    logic [W-1:0]    s_rem [0:W];
    logic [W-1:0]    s_nq  [0:W];
    logic [W-1:0]    s_div [0:W];

    // advance whenever the output slot is empty or being taken
    assign en         = ~s_ctl[W].valid | o_out.ready;
    assign i_in.ready = en;

    assign dividend_full = {i_in.dividend_hi, i_in.dividend_lo};
    assign divisor_full  = {i_in.divisor_hi, i_in.divisor_lo};

    assign s_ctl[0].valid = i_in.valid;
    assign s_ctl[0].dz    = (divisor_full[W-1:0] == '0);
    assign s_rem[0]       = '0;
    assign s_nq[0]        = dividend_full[W-1:0];
    assign s_div[0]       = divisor_full[W-1:0];

    for (genvar k = 0; k < W; k++) begin : g_stage
        ud128_stage #(.W(W)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (s_ctl[k]),
            .i_rem   (s_rem[k]),
            .i_nq    (s_nq[k]),
            .i_div   (s_div[k]),
            .o_ctl   (s_ctl[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_nq    (s_nq[k+1]),
            .o_div   (s_div[k+1])
        );
    end

    // divisor of zero leaves all-ones quotient in the datapath; force to zero
    assign quot_full = s_ctl[W].dz ? '0 : ud128_pkg::FULL_W'(s_nq[W]);
    assign rem_full  = s_ctl[W].dz ? '0 : ud128_pkg::FULL_W'(s_rem[W]);

    assign o_out.valid          = s_ctl[W].valid;
    assign o_out.quotient_hi    = quot_full[ud128_pkg::FULL_W-1:ud128_pkg::FIELD_W];
    assign o_out.quotient_lo    = quot_full[ud128_pkg::FIELD_W-1:0];
    assign o_out.remainder_hi   = rem_full[ud128_pkg::FULL_W-1:ud128_pkg::FIELD_W];
    assign o_out.remainder_lo   = rem_full[ud128_pkg::FIELD_W-1:0];
    assign o_out.divide_by_zero = s_ctl[W].dz;

    // s_div at the end is carried for uniformity of the stage chain
    logic unused_div;
    assign unused_div = ^s_div[W];

endmodule

// ----- src/ud128_chk.sv -----
// Port-level assertion checker for the divider, bound to the top level.
module ud128_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ud128_pkg::FIELD_W-1:0] i_quotient_hi,
    input logic [ud128_pkg::FIELD_W-1:0] i_quotient_lo,
    input logic [ud128_pkg::FIELD_W-1:0] i_remainder_hi,
    input logic [ud128_pkg::FIELD_W-1:0] i_remainder_lo,
    input logic                          i_divide_by_zero
);

    // a stalled result freezes the pipeline, so no new transaction enters
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input accepted while output stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_quotient_lo) && $stable(i_remainder_lo)
             && $stable(i_divide_by_zero)))
        else $error("stalled result changed");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_divide_by_zero) |->
            (i_quotient_hi == '0 && i_quotient_lo == '0 &&
             i_remainder_hi == '0 && i_remainder_lo == '0))
        else $error("divide by zero result not cleared");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind unsigned_divide_128 ud128_chk u_ud128_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_quotient_hi    (o_out.quotient_hi),
    .i_quotient_lo    (o_out.quotient_lo),
    .i_remainder_hi   (o_out.remainder_hi),
    .i_remainder_lo   (o_out.remainder_lo),
    .i_divide_by_zero (o_out.divide_by_zero)
);
